>>> hw/rtl/btve_pkg.sv
// ============================================================================
// BACnet tagged value encoder package
// Shared types and constants: value kinds, result status codes, the job
// record that the front end hands to the back end, and encoding constants.
// ============================================================================
package btve_pkg;

  // Value kinds, in the order of the action code.
  typedef enum logic [3:0] {
    ACT_NULL         = 4'd0,
    ACT_BOOL         = 4'd1,
    ACT_UNSIGNED     = 4'd2,
    ACT_ENUM         = 4'd3,
    ACT_SIGNED       = 4'd4,
    ACT_REAL         = 4'd5,
    ACT_DOUBLE       = 4'd6,
    ACT_DATE         = 4'd7,
    ACT_TIME         = 4'd8,
    ACT_OID          = 4'd9,
    ACT_CTX_UNSIGNED = 4'd10,
    ACT_CTX_ENUM     = 4'd11,
    ACT_CTX_SIGNED   = 4'd12,
    ACT_CTX_BOOL     = 4'd13,
    ACT_OPEN         = 4'd14,
    ACT_CLOSE        = 4'd15
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_ROOM = 2'd2
  } status_e;

  localparam int unsigned MaxOctets  = 10;
  localparam int unsigned OctetsW    = 8 * MaxOctets;
  localparam int unsigned LenW       = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = 1;
  localparam int unsigned QCountW    = 2;

  // Application tag numbers.
  localparam logic [7:0] TAG_NULL     = 8'd0;
  localparam logic [7:0] TAG_BOOL     = 8'd1;
  localparam logic [7:0] TAG_UNSIGNED = 8'd2;
  localparam logic [7:0] TAG_SIGNED   = 8'd3;
  localparam logic [7:0] TAG_REAL     = 8'd4;
  localparam logic [7:0] TAG_DOUBLE   = 8'd5;
  localparam logic [7:0] TAG_ENUM     = 8'd9;
  localparam logic [7:0] TAG_DATE     = 8'd10;
  localparam logic [7:0] TAG_TIME     = 8'd11;
  localparam logic [7:0] TAG_OID      = 8'd12;

  localparam logic [7:0] TAG_EXT_MIN  = 8'd15;
  localparam logic [7:0] TAG_RESERVED = 8'd255;
  localparam logic [3:0] TAG_EXT_NIB  = 4'hF;

  localparam logic [2:0] LVT_EXT_LEN  = 3'd5;
  localparam logic [2:0] LVT_OPEN     = 3'd6;
  localparam logic [2:0] LVT_CLOSE    = 3'd7;

  localparam logic [30:0] REAL_INF_MAG   = 31'h7F80_0000;
  localparam logic [62:0] DOUBLE_INF_MAG = 63'h7FF0_0000_0000_0000;
  localparam logic [63:0] OID_INST_MAX   = 64'h0000_0000_003F_FFFF;
  localparam logic [15:0] OID_TYPE_MAX   = 16'd1023;
  localparam logic [15:0] YEAR_BASE      = 16'd1900;
  localparam logic [15:0] YEAR_MAX       = 16'd2154;
  localparam logic [15:0] YEAR_UNSPEC    = 16'hFFFF;
  localparam logic [7:0]  FIELD_UNSPEC   = 8'hFF;

  // One encoded item: octets left-aligned, first octet in the top byte.
  typedef struct packed {
    logic [OctetsW-1:0] octets;
    logic [LenW-1:0]    len;
    status_e            status;
  } job_t;

endpackage

>>> hw/rtl/btve_front.sv
// ============================================================================
// BACnet tagged value encoder front end
// Accepts one value item, checks it and builds the complete octet string
// (header, extended tag or length octet, minimal content) as one job record.
// ============================================================================
module btve_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        action_i,
  input  logic [7:0]        tag_number_i,
  input  logic [63:0]       value_i,
  input  logic [15:0]       year_or_type_i,
  input  logic [7:0]        hour_i,
  input  logic [7:0]        month_or_minute_i,
  input  logic [7:0]        day_or_second_i,
  input  logic [7:0]        weekday_or_hundredths_i,
  input  logic [7:0]        room_i,
  input  logic              q_full_i,
  output logic              push_o,
  output btve_pkg::job_t    job_o
);

  function automatic logic in_or_unspec(input logic [7:0] x, input logic [7:0] lo,
                                        input logic [7:0] hi);
    return ((x >= lo) && (x <= hi)) || (x == btve_pkg::FIELD_UNSPEC);
  endfunction

  btve_pkg::action_e act;
  logic [31:0] v32;
  logic [31:0] int_v;
  logic        int_sgn;
  logic [31:0] int_mag;
  logic [2:0]  int_len;
  logic        year_ok;
  logic [7:0]  year_code;
  logic [15:0] year_off;
  logic [7:0]  tag;
  logic        ctx;
  logic [2:0]  lvt;
  logic [3:0]  clen;
  logic [63:0] cval;
  logic        bad_value;
  logic        ext_tag;
  logic        ext_len;
  logic [1:0]  hl;
  logic [7:0]  h0;
  logic [23:0] hdr;
  logic [63:0] content;
  logic [btve_pkg::OctetsW-1:0] body;
  logic [3:0]  total;
  btve_pkg::status_e status;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  assign act = btve_pkg::action_e'(action_i);
  assign v32 = value_i[31:0];

  // Integer operand and its minimal content length.
  always_comb begin
    int_v   = (act == btve_pkg::ACT_CTX_BOOL) ? {31'd0, value_i[0]} : v32;
    int_sgn = (act == btve_pkg::ACT_SIGNED) || (act == btve_pkg::ACT_CTX_SIGNED);
    int_mag = (int_sgn && int_v[31]) ? ~int_v : int_v;
    if (int_sgn) begin
      if (|int_mag[31:23])      int_len = 3'd4;
      else if (|int_mag[22:15]) int_len = 3'd3;
      else if (|int_mag[14:7])  int_len = 3'd2;
      else                      int_len = 3'd1;
    end else begin
      if (|int_mag[31:24])      int_len = 3'd4;
      else if (|int_mag[23:16]) int_len = 3'd3;
      else if (|int_mag[15:8])  int_len = 3'd2;
      else                      int_len = 3'd1;
    end
  end

  // Date year becomes an offset from 1900, or 255 when unspecified.
  always_comb begin
    year_off = year_or_type_i - btve_pkg::YEAR_BASE;
    year_ok  = 1'b1;
    if (year_or_type_i == btve_pkg::YEAR_UNSPEC) begin
      year_code = 8'hFF;
    end else begin
      year_code = year_off[7:0];
      year_ok   = (year_or_type_i >= btve_pkg::YEAR_BASE) &&
                  (year_or_type_i <= btve_pkg::YEAR_MAX);
    end
  end

  always_comb begin
    tag       = btve_pkg::TAG_NULL;
    ctx       = 1'b0;
    lvt       = 3'd0;
    clen      = 4'd0;
    cval      = 64'd0;
    bad_value = 1'b0;
    case (act)
      btve_pkg::ACT_NULL: begin
        tag = btve_pkg::TAG_NULL;
      end
      btve_pkg::ACT_BOOL: begin
        tag = btve_pkg::TAG_BOOL;
        lvt = {2'b00, value_i[0]};
      end
      btve_pkg::ACT_UNSIGNED, btve_pkg::ACT_ENUM, btve_pkg::ACT_SIGNED: begin
        if (act == btve_pkg::ACT_UNSIGNED)  tag = btve_pkg::TAG_UNSIGNED;
        else if (act == btve_pkg::ACT_ENUM) tag = btve_pkg::TAG_ENUM;
        else                                tag = btve_pkg::TAG_SIGNED;
        lvt  = int_len;
        clen = {1'b0, int_len};
        cval = {32'd0, int_v};
      end
      btve_pkg::ACT_REAL: begin
        tag       = btve_pkg::TAG_REAL;
        lvt       = 3'd4;
        clen      = 4'd4;
        cval      = {32'd0, v32};
        bad_value = v32[30:0] > btve_pkg::REAL_INF_MAG;
      end
      btve_pkg::ACT_DOUBLE: begin
        tag       = btve_pkg::TAG_DOUBLE;
        lvt       = btve_pkg::LVT_EXT_LEN;
        clen      = 4'd8;
        cval      = value_i;
        bad_value = value_i[62:0] > btve_pkg::DOUBLE_INF_MAG;
      end
      btve_pkg::ACT_DATE: begin
        tag       = btve_pkg::TAG_DATE;
        lvt       = 3'd4;
        clen      = 4'd4;
        cval      = {32'd0, year_code, month_or_minute_i, day_or_second_i,
                     weekday_or_hundredths_i};
        bad_value = !year_ok ||
                    !in_or_unspec(month_or_minute_i, 8'd1, 8'd14) ||
                    !in_or_unspec(day_or_second_i, 8'd1, 8'd34) ||
                    !in_or_unspec(weekday_or_hundredths_i, 8'd1, 8'd7);
      end
      btve_pkg::ACT_TIME: begin
        tag       = btve_pkg::TAG_TIME;
        lvt       = 3'd4;
        clen      = 4'd4;
        cval      = {32'd0, hour_i, month_or_minute_i, day_or_second_i,
                     weekday_or_hundredths_i};
        bad_value = !in_or_unspec(hour_i, 8'd0, 8'd23) ||
                    !in_or_unspec(month_or_minute_i, 8'd0, 8'd59) ||
                    !in_or_unspec(day_or_second_i, 8'd0, 8'd59) ||
                    !in_or_unspec(weekday_or_hundredths_i, 8'd0, 8'd99);
      end
      btve_pkg::ACT_OID: begin
        tag       = btve_pkg::TAG_OID;
        lvt       = 3'd4;
        clen      = 4'd4;
        cval      = {32'd0, year_or_type_i[9:0], value_i[21:0]};
        bad_value = (year_or_type_i > btve_pkg::OID_TYPE_MAX) ||
                    (value_i > btve_pkg::OID_INST_MAX);
      end
      btve_pkg::ACT_CTX_UNSIGNED, btve_pkg::ACT_CTX_ENUM,
      btve_pkg::ACT_CTX_SIGNED, btve_pkg::ACT_CTX_BOOL: begin
        tag  = tag_number_i;
        ctx  = 1'b1;
        lvt  = int_len;
        clen = {1'b0, int_len};
        cval = {32'd0, int_v};
      end
      btve_pkg::ACT_OPEN: begin
        tag = tag_number_i;
        ctx = 1'b1;
        lvt = btve_pkg::LVT_OPEN;
      end
      btve_pkg::ACT_CLOSE: begin
        tag = tag_number_i;
        ctx = 1'b1;
        lvt = btve_pkg::LVT_CLOSE;
      end
      default: begin
        tag = btve_pkg::TAG_NULL;
      end
    endcase
  end

  // Header octets sit left-aligned in hdr; the content follows right after them.
  always_comb begin
    ext_tag = tag >= btve_pkg::TAG_EXT_MIN;
    ext_len = clen >= 4'd5;
    hl      = 2'd1 + {1'b0, ext_tag} + {1'b0, ext_len};
    h0      = {(ext_tag ? btve_pkg::TAG_EXT_NIB : tag[3:0]), ctx, lvt};
    if (ext_tag)      hdr = {h0, tag, 8'h00};
    else if (ext_len) hdr = {h0, 4'h0, clen, 8'h00};
    else              hdr = {h0, 16'h0000};
    content = cval << {(4'd8 - clen), 3'b000};
    body    = {content, 16'h0000} >> {hl, 3'b000};
    total   = {2'b00, hl} + clen;

    if (bad_value || (tag == btve_pkg::TAG_RESERVED)) status = btve_pkg::ST_INVALID;
    else if (room_i < {4'd0, total})                  status = btve_pkg::ST_NO_ROOM;
    else                                              status = btve_pkg::ST_OK;

    job_o.status = status;
    if (status == btve_pkg::ST_OK) begin
      job_o.octets = {hdr, 56'd0} | body;
      job_o.len    = total;
    end else begin
      job_o.octets = '0;
      job_o.len    = 4'd1;
    end
  end

endmodule

>>> hw/rtl/btve_queue.sv
// ============================================================================
// BACnet tagged value encoder job queue
// Two-entry queue of encoded jobs between the front end and the serializer.
// ============================================================================
module btve_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  btve_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output btve_pkg::job_t job_o
);

  btve_pkg::job_t entries_q [btve_pkg::QueueDepth];
  logic [btve_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [btve_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [btve_pkg::QCountW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == btve_pkg::QCountW'(btve_pkg::QueueDepth);
  assign job_o   = entries_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop)      count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> hw/rtl/btve_back.sv
// ============================================================================
// BACnet tagged value encoder back end
// Serializes one job at a time into octet results through an output register,
// taking the next job from the queue when idle or in the cycle the last octet leaves.
// ============================================================================
module btve_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  btve_pkg::job_t q_job_i,
  output logic           pop_o,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           last_o,
  output logic [1:0]     status_o
);

  logic                          busy_q, busy_d;
  logic [btve_pkg::LenW-1:0]     rem_q, rem_d;
  logic [btve_pkg::OctetsW-1:0]  vec_q, vec_d;
  btve_pkg::status_e             stat_q, stat_d;
  logic                          ovalid_q, ovalid_d;
  logic [7:0]                    obyte_q, obyte_d;
  logic                          olast_q, olast_d;
  btve_pkg::status_e             ostat_q, ostat_d;
  logic advance, finishing, load;

  assign advance   = !ovalid_q || !out_stall_i;
  assign finishing = advance && busy_q && (rem_q == btve_pkg::LenW'(1));
  assign load      = q_valid_i && (!busy_q || finishing);
  assign pop_o     = load;
  assign busy_o    = busy_q;

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;
  assign status_o    = ostat_q;

  always_comb begin
    busy_d   = busy_q;
    rem_d    = rem_q;
    vec_d    = vec_q;
    stat_d   = stat_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    ostat_d  = ostat_q;
    if (advance) begin
      ovalid_d = busy_q;
      if (busy_q) begin
        obyte_d = vec_q[btve_pkg::OctetsW-1 -: 8];
        olast_d = rem_q == btve_pkg::LenW'(1);
        ostat_d = stat_q;
        vec_d   = vec_q << 8;
        rem_d   = rem_q - 1'b1;
        if (rem_q == btve_pkg::LenW'(1)) begin
          busy_d = 1'b0;
        end
      end
    end
    // A new job overrides the finished one in the same cycle.
    if (load) begin
      busy_d = 1'b1;
      vec_d  = q_job_i.octets;
      rem_d  = q_job_i.len;
      stat_d = q_job_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rem_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      rem_q    <= rem_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q   <= vec_d;
    stat_q  <= stat_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
  end

endmodule

>>> hw/rtl/bacnet_tagged_value_encoder_core.sv
// ============================================================================
// BACnet tagged value encoder core
// Encodes one typed value per item into its BACnet tagged octet string and
// emits it one octet per result, marking the final octet with last.
// ============================================================================
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o    | action, tag, value, date/time, room
//  out     | out_valid_o / out_stall_i  | out_byte, last, status
//
// The serializer sends one octet per cycle while the output is not stalled; an item
// has 1 to 10 result octets, and a status result is a single octet.
// The first octet of an item passes the queue, the job register and the output register.
// The front end encodes in the accept cycle and parks the job in a two-entry
// queue, so input is taken while output is stalled until the queue is full.
// Reset clears the queue and the serializer; nothing else holds state.
//
module bacnet_tagged_value_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [7:0]  tag_number_i,
  input  logic [63:0] value_i,
  input  logic [15:0] year_or_type_i,
  input  logic [7:0]  hour_i,
  input  logic [7:0]  month_or_minute_i,
  input  logic [7:0]  day_or_second_i,
  input  logic [7:0]  weekday_or_hundredths_i,
  input  logic [7:0]  room_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o
);

  btve_pkg::job_t front_job, q_job;
  logic push, q_full, q_valid, pop, back_busy;

  btve_front u_front (
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .action_i                (action_i),
    .tag_number_i            (tag_number_i),
    .value_i                 (value_i),
    .year_or_type_i          (year_or_type_i),
    .hour_i                  (hour_i),
    .month_or_minute_i       (month_or_minute_i),
    .day_or_second_i         (day_or_second_i),
    .weekday_or_hundredths_i (weekday_or_hundredths_i),
    .room_i                  (room_i),
    .q_full_i                (q_full),
    .push_o                  (push),
    .job_o                   (front_job)
  );

  btve_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .job_o   (q_job)
  );

  btve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  // An error result is a single result with a zero octet that closes its item.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != btve_pkg::ST_OK)) |-> (last_o && (out_byte_o == 8'h00)))
    else $error("error result without last or with nonzero octet");

  // An accepted item is in the queue or already taken by the serializer.
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (q_valid || back_busy))
    else $error("accepted item lost before the serializer");

  // With nothing queued or in flight, no result can appear.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_valid && !back_busy && !out_valid_o && !(in_valid_i && !in_stall_o))
      |=> !out_valid_o)
    else $error("result produced with no item in flight");

endmodule

>>> tb/tb_top.sv
// ============================================================================
// Testbench for the BACnet tagged value encoder core
// Drives typed values to encode over the valid/stall input channel and checks
// every octet, last flag and status that leaves the output channel against
// the encoding predicted in the bench. Directed corner cases come first, then
// random items with random idling on both sides and long receiver hold-offs.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
  import btve_pkg::*;

  typedef struct packed {
    action_e     act;
    logic [7:0]  tag;
    logic [63:0] value;
    logic [15:0] yt;
    logic [7:0]  hr;
    logic [7:0]  mm;
    logic [7:0]  ds;
    logic [7:0]  wh;
    logic [7:0]  room;
  } value_item_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    status_e    st;
  } octet_result_t;

  localparam int RandomItems = 442;
  localparam int DrainCycles = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [7:0] out_byte;
  logic out_last;
  logic [1:0] out_status;

  value_item_t   cur_item = '0;
  value_item_t   pending_values [$];
  octet_result_t expected_octets [$];

  int  offer_cnt = 0;
  int  acc_cnt = 0;
  int  mismatch_cnt = 0;
  int  tx_left = 0;
  int  rx_left = 0;
  int  tx_cycle = 0;
  int  rx_cycle = 0;
  bit  calm_tx = 1'b0;
  bit  calm_rx = 1'b0;
  logic hold_rx = 1'b0;

  always #1 clk = ~clk;

  bacnet_tagged_value_encoder_core u_top (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .action_i                (cur_item.act),
    .tag_number_i            (cur_item.tag),
    .value_i                 (cur_item.value),
    .year_or_type_i          (cur_item.yt),
    .hour_i                  (cur_item.hr),
    .month_or_minute_i       (cur_item.mm),
    .day_or_second_i         (cur_item.ds),
    .weekday_or_hundredths_i (cur_item.wh),
    .room_i                  (cur_item.room),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .out_byte_o              (out_byte),
    .last_o                  (out_last),
    .status_o                (out_status)
  );

  function automatic bit in_span(logic [7:0] x, logic [7:0] lo, logic [7:0] hi);
    return (x >= lo && x <= hi) || x == FIELD_UNSPEC;
  endfunction

  function automatic void push_status(status_e st);
    octet_result_t r;
    r.octet = 8'h00;
    r.last  = 1'b1;
    r.st    = st;
    expected_octets.push_back(r);
  endfunction

  // Works out the tagged encoding of one accepted item and queues its results.
  function automatic void predict_encoding(value_item_t it);
    logic [7:0]  tag;
    logic [7:0]  h0;
    logic [7:0]  y;
    logic [2:0]  lvt;
    logic [31:0] v32;
    logic [31:0] mag;
    logic [63:0] content;
    logic [63:0] tmp;
    logic [7:0]  seq [$];
    octet_result_t r;
    bit ctx, len_mode, is_int, sgn, bad;
    int clen, hl, adj;

    tag = it.tag;
    v32 = it.value[31:0];
    ctx = 1'b0;
    len_mode = 1'b1;
    lvt = 3'd0;
    clen = 0;
    content = 64'd0;
    is_int = 1'b0;
    sgn = 1'b0;
    bad = 1'b0;
    y = 8'd0;
    case (it.act)
      ACT_NULL: tag = TAG_NULL;
      ACT_BOOL: begin
        tag = TAG_BOOL;
        len_mode = 1'b0;
        lvt = {2'b00, it.value[0]};
      end
      ACT_UNSIGNED: begin
        tag = TAG_UNSIGNED;
        is_int = 1'b1;
      end
      ACT_ENUM: begin
        tag = TAG_ENUM;
        is_int = 1'b1;
      end
      ACT_SIGNED: begin
        tag = TAG_SIGNED;
        is_int = 1'b1;
        sgn = 1'b1;
      end
      ACT_REAL: begin
        tag = TAG_REAL;
        clen = 4;
        content = {32'd0, v32};
        bad = v32[30:0] > REAL_INF_MAG;
      end
      ACT_DOUBLE: begin
        tag = TAG_DOUBLE;
        clen = 8;
        content = it.value;
        bad = it.value[62:0] > DOUBLE_INF_MAG;
      end
      ACT_DATE: begin
        tag = TAG_DATE;
        clen = 4;
        if (it.yt == YEAR_UNSPEC) y = 8'hFF;
        else if (it.yt >= YEAR_BASE && it.yt <= YEAR_MAX) y = 8'(it.yt - YEAR_BASE);
        else bad = 1'b1;
        if (!in_span(it.mm, 8'd1, 8'd14) || !in_span(it.ds, 8'd1, 8'd34) ||
            !in_span(it.wh, 8'd1, 8'd7)) bad = 1'b1;
        content = {32'd0, y, it.mm, it.ds, it.wh};
      end
      ACT_TIME: begin
        tag = TAG_TIME;
        clen = 4;
        bad = !in_span(it.hr, 8'd0, 8'd23) || !in_span(it.mm, 8'd0, 8'd59) ||
              !in_span(it.ds, 8'd0, 8'd59) || !in_span(it.wh, 8'd0, 8'd99);
        content = {32'd0, it.hr, it.mm, it.ds, it.wh};
      end
      ACT_OID: begin
        tag = TAG_OID;
        clen = 4;
        bad = it.yt > OID_TYPE_MAX || it.value > OID_INST_MAX;
        content = {32'd0, it.yt[9:0], it.value[21:0]};
      end
      ACT_CTX_UNSIGNED, ACT_CTX_ENUM: begin
        ctx = 1'b1;
        is_int = 1'b1;
      end
      ACT_CTX_SIGNED: begin
        ctx = 1'b1;
        is_int = 1'b1;
        sgn = 1'b1;
      end
      ACT_CTX_BOOL: begin
        ctx = 1'b1;
        is_int = 1'b1;
        v32 = {31'd0, it.value[0]};
      end
      ACT_OPEN: begin
        ctx = 1'b1;
        len_mode = 1'b0;
        lvt = LVT_OPEN;
      end
      default: begin
        ctx = 1'b1;
        len_mode = 1'b0;
        lvt = LVT_CLOSE;
      end
    endcase

    // Minimal length: a signed value keeps one spare bit for its sign.
    if (is_int) begin
      mag = (sgn && v32[31]) ? ~v32 : v32;
      adj = sgn ? 1 : 0;
      clen = 1;
      while (clen < 4 && (mag >> (8 * clen - adj)) != 32'd0) clen++;
      content = {32'd0, v32};
    end

    if (bad || tag == TAG_RESERVED) begin
      push_status(ST_INVALID);
      return;
    end
    hl = 1 + ((tag >= TAG_EXT_MIN) ? 1 : 0) + ((len_mode && clen >= 5) ? 1 : 0);
    if (int'(it.room) < hl + clen) begin
      push_status(ST_NO_ROOM);
      return;
    end

    h0 = ctx ? 8'h08 : 8'h00;
    if (tag < TAG_EXT_MIN) h0 = h0 | {tag[3:0], 4'h0};
    else h0 = h0 | {TAG_EXT_NIB, 4'h0};
    if (!len_mode) h0 = h0 | {5'd0, lvt};
    else if (clen < 5) h0 = h0 | 8'(clen);
    else h0 = h0 | {5'd0, LVT_EXT_LEN};
    seq.push_back(h0);
    if (tag >= TAG_EXT_MIN) seq.push_back(tag);
    if (len_mode && clen >= 5) seq.push_back(8'(clen));
    for (int i = 0; i < clen; i++) begin
      tmp = content >> (8 * (clen - 1 - i));
      seq.push_back(tmp[7:0]);
    end
    for (int i = 0; i < seq.size(); i++) begin
      r.octet = seq[i];
      r.last  = (i == seq.size() - 1);
      r.st    = ST_OK;
      expected_octets.push_back(r);
    end
  endfunction

  function automatic value_item_t mk_value(action_e act, logic [7:0] tag, logic [63:0] value,
                                           logic [15:0] yt, logic [7:0] hr, logic [7:0] mm,
                                           logic [7:0] ds, logic [7:0] wh, logic [7:0] room);
    value_item_t it;
    it.act = act;
    it.tag = tag;
    it.value = value;
    it.yt = yt;
    it.hr = hr;
    it.mm = mm;
    it.ds = ds;
    it.wh = wh;
    it.room = room;
    return it;
  endfunction

  // Mostly in range, sometimes unspecified, sometimes any octet at all.
  function automatic logic [7:0] field_pick(int lo, int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(lo, hi));
    if (r < 92) return FIELD_UNSPEC;
    return 8'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic value_item_t rand_value_item();
    value_item_t it;
    logic [31:0] lo;
    int r;
    it.act   = action_e'($urandom_range(0, 15));
    it.value = {$urandom, $urandom};
    it.yt    = 16'($urandom);
    it.hr    = 8'($urandom);
    it.mm    = 8'($urandom);
    it.ds    = 8'($urandom);
    it.wh    = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 65) it.tag = 8'($urandom_range(0, 14));
    else if (r < 92) it.tag = 8'($urandom_range(15, 254));
    else if (r < 96) it.tag = TAG_RESERVED;
    else it.tag = 8'($urandom);
    r = $urandom_range(0, 99);
    it.room = (r < 20) ? 8'($urandom_range(0, 11)) : 8'($urandom_range(0, 255));

    case (it.act)
      ACT_UNSIGNED, ACT_ENUM, ACT_SIGNED, ACT_CTX_UNSIGNED, ACT_CTX_ENUM,
      ACT_CTX_SIGNED: begin
        // Spread the magnitude so every content length comes up.
        lo = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) lo = ~lo;
        it.value[31:0] = lo;
      end
      ACT_REAL: begin
        r = $urandom_range(0, 99);
        if (r < 15) it.value[30:23] = 8'hFF;
        if (r < 6) it.value[22:0] = 23'd0;
      end
      ACT_DOUBLE: begin
        r = $urandom_range(0, 99);
        if (r < 15) it.value[62:52] = 11'h7FF;
        if (r < 6) it.value[51:0] = 52'd0;
      end
      ACT_DATE: begin
        r = $urandom_range(0, 99);
        if (r < 75) it.yt = 16'($urandom_range(1900, 2154));
        else if (r < 88) it.yt = YEAR_UNSPEC;
        it.mm = field_pick(1, 14);
        it.ds = field_pick(1, 34);
        it.wh = field_pick(1, 7);
      end
      ACT_TIME: begin
        it.hr = field_pick(0, 23);
        it.mm = field_pick(0, 59);
        it.ds = field_pick(0, 59);
        it.wh = field_pick(0, 99);
      end
      ACT_OID: begin
        if ($urandom_range(0, 99) < 85) it.yt = 16'($urandom_range(0, 1023));
        if ($urandom_range(0, 99) < 85) it.value = 64'($urandom_range(0, 32'h3FFFFF));
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Sender: offers the next pending item at the falling edge, holds it while stalled.
  always @(negedge clk) begin : drive_items
    if (rst_n) begin
      tx_cycle++;
      if (tx_cycle % 128 == 0) calm_tx = ($urandom_range(0, 3) == 0);
      if (in_valid && offer_cnt != acc_cnt) begin
        // Still waiting for the current item to be taken.
      end else if (tx_left > 0) begin
        in_valid <= 1'b0;
        tx_left--;
      end else if (pending_values.size() > 0) begin
        cur_item = pending_values.pop_front();
        in_valid <= 1'b1;
        offer_cnt++;
        tx_left = calm_tx ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with an external hold-off that overrides the random pattern.
  always @(negedge clk) begin : drive_stall
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      if (hold_rx) begin
        out_stall <= 1'b1;
      end else if (rx_left > 0) begin
        out_stall <= 1'b1;
        rx_left--;
      end else if (!calm_rx && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        rx_left = pick_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    octet_result_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_encoding(cur_item);
        acc_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (expected_octets.size() == 0) begin
          report_mismatch($sformatf("result %02h with nothing expected", out_byte));
        end else begin
          exp_r = expected_octets.pop_front();
          if (out_byte !== exp_r.octet)
            report_mismatch($sformatf("octet %02h, expected %02h", out_byte, exp_r.octet));
          if (out_last !== exp_r.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_last, exp_r.last));
          if (out_status !== exp_r.st)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_r.st));
        end
      end
    end
  end

  // Two long receiver hold-offs so the block fills and stalls its input.
  initial begin : hold_off
    wait (acc_cnt >= 60);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rx <= 1'b0;
    wait (acc_cnt >= 300);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #10000000;
    $display("FAIL bacnet_tagged_value_encoder_core");
    $finish;
  end

  initial begin : main_seq
    int total;
    // Directed corners.
    pending_values.push_back(mk_value(ACT_NULL, 8'd0, 64'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd1));
    pending_values.push_back(mk_value(ACT_NULL, 8'hFF, '1, '1, '1, '1, '1, '1, 8'd0));
    pending_values.push_back(mk_value(ACT_BOOL, 8'hFF, 64'd1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd1));
    pending_values.push_back(mk_value(ACT_BOOL, 8'd0, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0, 8'd0,
                                      8'd0, 8'd0, 8'd0, 8'hFF));
    pending_values.push_back(mk_value(ACT_UNSIGNED, 8'd0, 64'd0, 16'd0, 8'd0, 8'd0, 8'd0,
                                      8'd0, 8'd2));
    pending_values.push_back(mk_value(ACT_UNSIGNED, 8'd0, '1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd5));
    pending_values.push_back(mk_value(ACT_ENUM, 8'd0, 64'd256, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd2));
    pending_values.push_back(mk_value(ACT_SIGNED, 8'd0, 64'hFFFF_FFFF, 16'd0, 8'd0, 8'd0, 8'd0,
                                      8'd0, 8'd2));
    pending_values.push_back(mk_value(ACT_SIGNED, 8'd0, 64'h8000_0000, 16'd0, 8'd0, 8'd0, 8'd0,
                                      8'd0, 8'd5));
    pending_values.push_back(mk_value(ACT_SIGNED, 8'd0, 64'h80, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd3));
    pending_values.push_back(mk_value(ACT_REAL, 8'd0, 64'h7FC0_0000, 16'd0, 8'd0, 8'd0, 8'd0,
                                      8'd0, 8'd5));
    pending_values.push_back(mk_value(ACT_REAL, 8'd0, 64'hFF80_0000, 16'd0, 8'd0, 8'd0, 8'd0,
                                      8'd0, 8'd5));
    pending_values.push_back(mk_value(ACT_DOUBLE, 8'd0, 64'hFFF8_0000_0000_0001, 16'd0, 8'd0,
                                      8'd0, 8'd0, 8'd0, 8'd10));
    pending_values.push_back(mk_value(ACT_DOUBLE, 8'd0, 64'h3FF0_0000_0000_0000, 16'd0, 8'd0,
                                      8'd0, 8'd0, 8'd0, 8'd10));
    pending_values.push_back(mk_value(ACT_DOUBLE, 8'd0, 64'h7FF0_0000_0000_0000, 16'd0, 8'd0,
                                      8'd0, 8'd0, 8'd0, 8'd9));
    pending_values.push_back(mk_value(ACT_DATE, 8'd0, 64'd0, 16'd2154, 8'd0, 8'd14, 8'd34,
                                      8'd7, 8'd5));
    pending_values.push_back(mk_value(ACT_DATE, 8'd0, 64'd0, YEAR_UNSPEC, 8'd0, 8'hFF, 8'hFF,
                                      8'hFF, 8'd5));
    pending_values.push_back(mk_value(ACT_DATE, 8'd0, 64'd0, 16'd1899, 8'd0, 8'd1, 8'd1,
                                      8'd1, 8'd5));
    pending_values.push_back(mk_value(ACT_TIME, 8'd0, 64'd0, 16'd0, 8'd23, 8'd59, 8'd59,
                                      8'd99, 8'd5));
    pending_values.push_back(mk_value(ACT_TIME, 8'd0, 64'd0, 16'd0, 8'd24, 8'd0, 8'd0, 8'd0,
                                      8'd5));
    pending_values.push_back(mk_value(ACT_OID, 8'd0, 64'h3F_FFFF, 16'd1023, 8'd0, 8'd0, 8'd0,
                                      8'd0, 8'd5));
    pending_values.push_back(mk_value(ACT_OID, 8'd0, 64'h40_0000, 16'd1024, 8'd0, 8'd0, 8'd0,
                                      8'd0, 8'd5));
    pending_values.push_back(mk_value(ACT_CTX_UNSIGNED, 8'd14, 64'd255, 16'd0, 8'd0, 8'd0,
                                      8'd0, 8'd0, 8'd2));
    pending_values.push_back(mk_value(ACT_CTX_ENUM, 8'd15, 64'h1_0000, 16'd0, 8'd0, 8'd0,
                                      8'd0, 8'd0, 8'd5));
    pending_values.push_back(mk_value(ACT_CTX_SIGNED, 8'd254, 64'hFFFF_8000, 16'd0, 8'd0,
                                      8'd0, 8'd0, 8'd0, 8'd4));
    pending_values.push_back(mk_value(ACT_CTX_BOOL, 8'd200, '1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd3));
    pending_values.push_back(mk_value(ACT_OPEN, 8'hFF, 64'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd5));
    pending_values.push_back(mk_value(ACT_CLOSE, 8'd254, 64'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                      8'd2));
    for (int i = 0; i < RandomItems; i++) pending_values.push_back(rand_value_item());
    total = pending_values.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(acc_cnt == total && expected_octets.size() == 0)) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0 && expected_octets.size() == 0) begin
      $display("PASS bacnet_tagged_value_encoder_core");
    end else begin
      $display("FAIL bacnet_tagged_value_encoder_core");
    end
    $finish;
  end

endmodule
